FILE: rtl/core/particle_swarm_velocity_update_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the particle swarm velocity update core
// Clocked concurrent checks, with and without the reset disable.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_SWARM_VELOCITY_UPDATE_CORE_ASSERT_SVH
`define PARTICLE_SWARM_VELOCITY_UPDATE_CORE_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define PSV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define PSV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also checks across reset.
`define PSV_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/psv_pkg.sv
// ----------------------------------------------------------------------------
// psv_pkg
// Types, constants and fixed-point helpers of the particle swarm update core.
// ----------------------------------------------------------------------------
package psv_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int RAND_BITS   = 16;
  localparam int DIMENSIONS  = 8;
  localparam int CFG_INDEX_W = 2;

  localparam logic signed [31:0] INERTIA_RESET   = 32'sd65536;
  localparam logic signed [31:0] COGNITIVE_RESET = 32'sd131072;
  localparam logic signed [31:0] SOCIAL_RESET    = 32'sd131072;
  localparam logic signed [31:0] VLIMIT_RESET    = 32'sd2147483647;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_INERTIA   = 2'd0,
    REG_COGNITIVE = 2'd1,
    REG_SOCIAL    = 2'd2,
    REG_VLIMIT    = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    HIT_NONE  = 2'd0,
    HIT_LOWER = 2'd1,
    HIT_UPPER = 2'd2
  } bound_hit_e;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] personal_best;
    logic signed [31:0] global_best;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic [15:0]        rand_one;
    logic [15:0]        rand_two;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] new_position;
    logic signed [31:0] new_velocity;
    logic [1:0]         bound_hit;
  } result_t;

  typedef struct packed {
    logic signed [31:0] inertia;
    logic signed [31:0] cognitive_gain;
    logic signed [31:0] social_gain;
    logic signed [31:0] velocity_limit;
  } cfg_t;

  // Fields that ride along unchanged until the bound check.
  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
  } carry_t;

  // Velocity pipe to position stage.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] velocity;
    carry_t             carry;
  } vel_item_t;

  localparam logic signed [64:0] SAT_HI = 65'sd2147483647;
  localparam logic signed [64:0] SAT_LO = -65'sd2147483648;

  function automatic logic signed [31:0] sat_to_32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Round half up then drop FRAC_BITS fraction bits, saturate.
  function automatic logic signed [31:0] rnd_sat_frac(input logic signed [63:0] p);
    logic signed [64:0] q;
    q = 65'(p) + (65'sd1 <<< (FRAC_BITS - 1));
    return sat_to_32(q >>> FRAC_BITS);
  endfunction

  // Round half up then drop RAND_BITS fraction bits, saturate.
  function automatic logic signed [31:0] rnd_sat_rand(input logic signed [63:0] p);
    logic signed [64:0] q;
    q = 65'(p) + (65'sd1 <<< (RAND_BITS - 1));
    return sat_to_32(q >>> RAND_BITS);
  endfunction

endpackage

FILE: rtl/core/psv_cfg_regs.sv
// ----------------------------------------------------------------------------
// psv_cfg_regs
// Gain and limit registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module psv_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [psv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [31:0]                      cfg_data,
  output psv_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inertia        <= psv_pkg::INERTIA_RESET;
      cfg.cognitive_gain <= psv_pkg::COGNITIVE_RESET;
      cfg.social_gain    <= psv_pkg::SOCIAL_RESET;
      cfg.velocity_limit <= psv_pkg::VLIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (psv_pkg::cfg_reg_e'(cfg_index))
        psv_pkg::REG_INERTIA:   cfg.inertia        <= $signed(cfg_data);
        psv_pkg::REG_COGNITIVE: cfg.cognitive_gain <= $signed(cfg_data);
        psv_pkg::REG_SOCIAL:    cfg.social_gain    <= $signed(cfg_data);
        psv_pkg::REG_VLIMIT:    cfg.velocity_limit <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/psv_velocity_pipe.sv
// ----------------------------------------------------------------------------
// psv_velocity_pipe
// Five register stages from an accepted item to the limited new velocity.
// ----------------------------------------------------------------------------
module psv_velocity_pipe (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                sample_valid,
  input  psv_pkg::sample_t    sample,
  input  psv_pkg::cfg_t       cfg,
  output psv_pkg::vel_item_t  vel
);

  // Stage 1: differences and first products.
  logic                   s1_valid;
  psv_pkg::carry_t        s1_carry;
  logic signed [31:0]     s1_d1, s1_d2;
  logic signed [48:0]     s1_pg1, s1_pg2;
  logic signed [63:0]     s1_pt0;
  // Stage 2: rounded gains and inertia term.
  logic                   s2_valid;
  psv_pkg::carry_t        s2_carry;
  logic signed [31:0]     s2_d1, s2_d2, s2_g1, s2_g2, s2_t0;
  // Stage 3: attraction products.
  logic                   s3_valid;
  psv_pkg::carry_t        s3_carry;
  logic signed [63:0]     s3_p1, s3_p2;
  logic signed [31:0]     s3_t0;
  // Stage 4: rounded attraction terms.
  logic                   s4_valid;
  psv_pkg::carry_t        s4_carry;
  logic signed [31:0]     s4_t0, s4_t1, s4_t2;
  // Stage 5: limited new velocity.
  logic                   s5_valid;
  psv_pkg::carry_t        s5_carry;
  logic signed [31:0]     s5_velocity;

  logic signed [32:0]     diff1, diff2;
  logic signed [33:0]     vsum;
  logic signed [31:0]     vsat;

  assign diff1 = 33'(sample.personal_best) - 33'(sample.position);
  assign diff2 = 33'(sample.global_best) - 33'(sample.position);
  assign vsum  = 34'(s4_t0) + 34'(s4_t1) + 34'(s4_t2);
  assign vsat  = psv_pkg::sat_to_32(65'(vsum));

  assign vel = '{valid: s5_valid, velocity: s5_velocity, carry: s5_carry};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= sample_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_carry.position    <= sample.position;
      s1_carry.lower_bound <= sample.lower_bound;
      s1_carry.upper_bound <= sample.upper_bound;
      s1_d1  <= psv_pkg::sat_to_32(65'(diff1));
      s1_d2  <= psv_pkg::sat_to_32(65'(diff2));
      s1_pg1 <= 49'(cfg.cognitive_gain) * 49'($signed({1'b0, sample.rand_one}));
      s1_pg2 <= 49'(cfg.social_gain) * 49'($signed({1'b0, sample.rand_two}));
      s1_pt0 <= 64'(cfg.inertia) * 64'(sample.velocity);

      s2_carry <= s1_carry;
      s2_d1    <= s1_d1;
      s2_d2    <= s1_d2;
      s2_g1    <= psv_pkg::rnd_sat_rand(64'(s1_pg1));
      s2_g2    <= psv_pkg::rnd_sat_rand(64'(s1_pg2));
      s2_t0    <= psv_pkg::rnd_sat_frac(s1_pt0);

      s3_carry <= s2_carry;
      s3_p1    <= 64'(s2_g1) * 64'(s2_d1);
      s3_p2    <= 64'(s2_g2) * 64'(s2_d2);
      s3_t0    <= s2_t0;

      s4_carry <= s3_carry;
      s4_t0    <= s3_t0;
      s4_t1    <= psv_pkg::rnd_sat_frac(s3_p1);
      s4_t2    <= psv_pkg::rnd_sat_frac(s3_p2);

      // Upper clamp only; a negative limit applies as written.
      s5_carry    <= s4_carry;
      s5_velocity <= (vsat > cfg.velocity_limit) ? cfg.velocity_limit : vsat;
    end
  end

endmodule

FILE: rtl/core/psv_position_stage.sv
// ----------------------------------------------------------------------------
// psv_position_stage
// New position, bound clamp and the result register.
// ----------------------------------------------------------------------------
module psv_position_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  psv_pkg::vel_item_t  vel,
  output logic                result_valid,
  output psv_pkg::result_t    result
);

  logic signed [32:0] psum;
  logic signed [31:0] pos_raw, pos_lo;
  logic               hit_lo, hit_hi;

  assign psum    = 33'(vel.carry.position) + 33'(vel.velocity);
  assign pos_raw = psv_pkg::sat_to_32(65'(psum));
  assign hit_lo  = pos_raw <= vel.carry.lower_bound;
  assign pos_lo  = hit_lo ? vel.carry.lower_bound : pos_raw;
  // The upper test sees the position after the lower clamp.
  assign hit_hi  = pos_lo >= vel.carry.upper_bound;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= vel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      priority if (hit_hi) begin
        result.new_position <= vel.carry.upper_bound;
        result.new_velocity <= '0;
        result.bound_hit    <= psv_pkg::HIT_UPPER;
      end else if (hit_lo) begin
        result.new_position <= vel.carry.lower_bound;
        result.new_velocity <= '0;
        result.bound_hit    <= psv_pkg::HIT_LOWER;
      end else begin
        result.new_position <= pos_raw;
        result.new_velocity <= vel.velocity;
        result.bound_hit    <= psv_pkg::HIT_NONE;
      end
    end
  end

endmodule

FILE: rtl/core/particle_swarm_velocity_update_core.sv
// ----------------------------------------------------------------------------
// particle_swarm_velocity_update_core
// Velocity and position update of one particle dimension per item, Q16.16.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Payload
//   -------   --------------------   -----------------------------------
//   sample    sample_valid / stall   psv_pkg::sample_t, one dimension
//   result    result_valid / stall   psv_pkg::result_t, one per sample
//   cfg       cfg_valid / cfg_ready  cfg_index (2 bits), cfg_data (32 bits)
//
// One item per clock while no held result is stalled; result_valid rises
// once the item has passed the six register stages (two multiplier stages
// with their rounding stages, the velocity sum, the position clamp), the
// first of which loads at the edge that accepts the item.
// Reset clears the valid bits and loads the register defaults: inertia 1.0,
// both gains 2.0, velocity limit unlimited.
// A stalled result freezes the whole pipe; sample_stall follows at once, so
// no item is lost or repeated. cfg_ready is always high.
//
// Data flow:
//   stage 1  pbest-x, gbest-x (saturated), c1*r1, c2*r2, inertia*v
//   stage 2  round and saturate gains and inertia term
//   stage 3  g1*d1, g2*d2
//   stage 4  round and saturate attraction terms
//   stage 5  exact three-term sum, saturate, clamp by the velocity limit
//   stage 6  x+v', lower then upper bound clamp, result register
// ----------------------------------------------------------------------------
module particle_swarm_velocity_update_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  psv_pkg::sample_t                 sample,
  output logic                             result_valid,
  input  logic                             result_stall,
  output psv_pkg::result_t                 result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [psv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [31:0]                      cfg_data
);

  psv_pkg::cfg_t      cfg;
  psv_pkg::vel_item_t vel;
  logic               advance;

  // Advance every stage unless a finished result is held by the receiver.
  assign advance      = !result_valid || !result_stall;
  assign sample_stall = !advance;
  assign cfg_ready    = 1'b1;

  psv_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  psv_velocity_pipe u_vel (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .sample_valid (sample_valid),
    .sample       (sample),
    .cfg          (cfg),
    .vel          (vel)
  );

  psv_position_stage u_pos (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .vel          (vel),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

FILE: rtl/core/psv_port_checker.sv
// ----------------------------------------------------------------------------
// psv_port_checker
// Port-level checks of the particle swarm update core, bound to the top.
// ----------------------------------------------------------------------------
`include "particle_swarm_velocity_update_core_assert.svh"

module psv_port_checker (
  input logic             clk,
  input logic             rst,
  input logic             sample_stall,
  input logic             result_valid,
  input logic             result_stall,
  input psv_pkg::result_t result
);

  `PSV_ASSERT_NEXT_ALWAYS(a_reset_empties, clk, rst, !result_valid, "result valid after reset")

  `PSV_ASSERT_NOW(a_stall_from_output, clk, rst, sample_stall, result_valid && result_stall, "input stalled without a held result")

  `PSV_ASSERT_NOW(a_hit_zero_velocity, clk, rst, result_valid && (result.bound_hit != psv_pkg::HIT_NONE), result.new_velocity == 32'sd0, "bound hit with nonzero velocity")

  `PSV_ASSERT_NEXT(a_result_holds, clk, rst, result_valid && result_stall, result_valid && $stable(result), "held result changed")

endmodule

bind particle_swarm_velocity_update_core psv_port_checker u_port_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
